// ===== rtl/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdq_pkg: shared types and constants of the sorted due queue
// Opcodes, status codes, default sizes and the per-cell command bundle.
// ----------------------------------------------------------------------------
package sdq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;
    localparam int unsigned DEF_KEY_WIDTH   = 32;
    localparam int unsigned DEF_TAG_WIDTH   = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic do_ins;
        logic do_rem;
    } t_cell_cmd;

endpackage

// ===== rtl/sdq_cell.sv =====
// ----------------------------------------------------------------------------
// sdq_cell: one slot of the sorted queue chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor; on remove it keeps or takes its right neighbor.
// ----------------------------------------------------------------------------
module sdq_cell #(
    parameter int unsigned KEY_WIDTH = sdq_pkg::DEF_KEY_WIDTH,
    parameter int unsigned TAG_WIDTH = sdq_pkg::DEF_TAG_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sdq_pkg::t_cell_cmd    i_cmd,
    input  logic [KEY_WIDTH-1:0]  i_new_key,
    input  logic [TAG_WIDTH-1:0]  i_new_tag,
    input  logic                  i_left_valid,
    input  logic [KEY_WIDTH-1:0]  i_left_key,
    input  logic [TAG_WIDTH-1:0]  i_left_tag,
    input  logic                  i_left_place,
    input  logic                  i_left_found,
    input  logic                  i_right_valid,
    input  logic [KEY_WIDTH-1:0]  i_right_key,
    input  logic [TAG_WIDTH-1:0]  i_right_tag,
    output logic                  o_valid,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic [TAG_WIDTH-1:0]  o_tag,
    output logic                  o_place,
    output logic                  o_found
);

    logic                 r_valid;
    logic [KEY_WIDTH-1:0] r_key;
    logic [TAG_WIDTH-1:0] r_tag;
    logic                 n_valid;
    logic [KEY_WIDTH-1:0] n_key;
    logic [TAG_WIDTH-1:0] n_tag;

    // new entry belongs here or further left when this slot is empty or not smaller
    assign o_place = !r_valid || (r_key >= i_new_key);
    // a match at or left of this slot
    assign o_found = i_left_found || (r_valid && (r_tag == i_new_tag));

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_tag   = r_tag;
        if (i_cmd.do_ins && o_place) begin
            if (i_left_place) begin
                n_valid = i_left_valid;
                n_key   = i_left_key;
                n_tag   = i_left_tag;
            end else begin
                n_valid = 1'b1;
                n_key   = i_new_key;
                n_tag   = i_new_tag;
            end
        end else if (i_cmd.do_rem && o_found) begin
            n_valid = i_right_valid;
            n_key   = i_right_key;
            n_tag   = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_tag   = r_tag;

endmodule

// ===== rtl/sorted_due_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_due_queue_unit: bounded queue of (due key, tag) kept in key order
// Top level: request handshake, fill counter, status and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one request per handshake. tuser carries the opcode
//   (insert or remove), tdata carries due_key (low bits) and item_tag.
//   Master side: one result per request. tuser carries the status,
//   tdata carries entry_count, head_valid, head_key and head_tag.
// Structure: a chain of QUEUE_DEPTH cells, cell 0 holding the head. All
//   cells compare against the request at once and shift one place left or
//   right together when the request is accepted.
// Result: the result appears in the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver takes results; the
//   rate is set by the single result register, which must be empty or
//   draining before the next request is taken.
// Reset: the queue comes up empty (all cell valid bits and the fill count
//   cleared) with no result pending.
// Stall: while the receiver holds off, the result is held and s_axis_tready
//   drops, so the queue contents and head stay frozen.
// ----------------------------------------------------------------------------
module sorted_due_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = sdq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned KEY_WIDTH   = sdq_pkg::DEF_KEY_WIDTH,
    parameter int unsigned TAG_WIDTH   = sdq_pkg::DEF_TAG_WIDTH,
    localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
    localparam int unsigned IN_DATA_W  = ((KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8,
    localparam int unsigned OUT_DATA_W =
        ((CNT_W + 1 + KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // from bit 0: due_key, item_tag, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // from bit 0: entry_count, head_valid, head_key, head_tag, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]            m_axis_tuser
);

    logic [KEY_WIDTH-1:0] req_key;
    logic [TAG_WIDTH-1:0] req_tag;
    logic                 accept;
    logic                 is_remove;
    logic                 full;
    logic                 any_found;
    sdq_pkg::t_cell_cmd   cmd;

    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [KEY_WIDTH-1:0]   cell_key [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0]   cell_tag [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_place;
    logic [QUEUE_DEPTH-1:0] cell_found;

    logic                  r_out_valid;
    sdq_pkg::t_status      r_status;
    logic [CNT_W-1:0]      r_fill;
    logic                  n_out_valid;
    sdq_pkg::t_status      n_status;
    logic [CNT_W-1:0]      n_fill;

    assign req_key   = s_axis_tdata[KEY_WIDTH-1:0];
    assign req_tag   = s_axis_tdata[KEY_WIDTH +: TAG_WIDTH];
    assign is_remove = (s_axis_tuser == sdq_pkg::OP_REMOVE);

    // take a request when the result slot is empty or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full      = (r_fill == CNT_W'(QUEUE_DEPTH));
    // last cell's running match covers the whole list
    assign any_found = cell_found[QUEUE_DEPTH-1];

    // drop inserts into a full list; a remove with no match moves nothing
    assign cmd.do_ins = accept && !is_remove && !full;
    assign cmd.do_rem = accept && is_remove;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                 left_valid;
        logic [KEY_WIDTH-1:0] left_key;
        logic [TAG_WIDTH-1:0] left_tag;
        logic                 left_place;
        logic                 left_found;
        logic                 right_valid;
        logic [KEY_WIDTH-1:0] right_key;
        logic [TAG_WIDTH-1:0] right_tag;

        if (g == 0) begin : g_head
            assign left_valid = 1'b0;
            assign left_key   = '0;
            assign left_tag   = '0;
            assign left_place = 1'b0;
            assign left_found = 1'b0;
        end else begin : g_mid
            assign left_valid = cell_valid[g-1];
            assign left_key   = cell_key[g-1];
            assign left_tag   = cell_tag[g-1];
            assign left_place = cell_place[g-1];
            assign left_found = cell_found[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_key   = '0;
            assign right_tag   = '0;
        end else begin : g_body
            assign right_valid = cell_valid[g+1];
            assign right_key   = cell_key[g+1];
            assign right_tag   = cell_tag[g+1];
        end

        sdq_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .TAG_WIDTH (TAG_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_new_key     (req_key),
            .i_new_tag     (req_tag),
            .i_left_valid  (left_valid),
            .i_left_key    (left_key),
            .i_left_tag    (left_tag),
            .i_left_place  (left_place),
            .i_left_found  (left_found),
            .i_right_valid (right_valid),
            .i_right_key   (right_key),
            .i_right_tag   (right_tag),
            .o_valid       (cell_valid[g]),
            .o_key         (cell_key[g]),
            .o_tag         (cell_tag[g]),
            .o_place       (cell_place[g]),
            .o_found       (cell_found[g])
        );
    end

    // status, fill count and result slot
    always_comb begin
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_fill      = r_fill;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_out_valid = 1'b1;
            if (!is_remove) begin
                if (full) begin
                    n_status = sdq_pkg::ST_FULL;
                end else begin
                    n_status = sdq_pkg::ST_DONE;
                    n_fill   = r_fill + CNT_W'(1);
                end
            end else begin
                if (any_found) begin
                    n_status = sdq_pkg::ST_DONE;
                    n_fill   = r_fill - CNT_W'(1);
                end else begin
                    n_status = sdq_pkg::ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // head comes straight from cell 0; it only moves together with the result
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = OUT_DATA_W'({
        (cell_valid[0] ? cell_tag[0] : {TAG_WIDTH{1'b0}}),
        (cell_valid[0] ? cell_key[0] : {KEY_WIDTH{1'b0}}),
        cell_valid[0],
        r_fill
    });

endmodule
